// ----- src/fpba_pkg.sv -----
`timescale 1ns / 1ps
package fpba_pkg;

  localparam int P_MEM_BYTES    = 4096;
  localparam int P_MAX_BLOCKS   = 16;
  localparam int P_HEADER_BYTES = 4;

  localparam int SIZE_W   = 12;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 13;
  localparam int HOLES_W  = 12;
  localparam int NEED_W   = 13;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 1'b1;

  typedef struct packed {
    logic                load;
    logic                scan_start;
    logic                scan_run;
    logic                look_start;
    logic                look_run;
    logic                commit;
    logic                mark_run;
    logic                clr_start;
    logic                set_st;
    logic [STATUS_W-1:0] st_code;
    logic                out_load;
  } fpba_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic look_hit;
    logic look_last;
    logic mark_done;
  } fpba_sts_t;

endpackage

// ----- src/fpba_if.sv -----
`timescale 1ns / 1ps
interface fpba_req_if import fpba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, req_type, size, address, input ready);
  modport sink   (input valid, req_type, size, address, output ready);
endinterface

interface fpba_rsp_if import fpba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address_out;
  logic [FREE_W-1:0]   free_bytes;
  logic [HOLES_W-1:0]  hole_count;

  modport source (output valid, status, address_out, free_bytes, hole_count, input ready);
  modport sink   (input valid, status, address_out, free_bytes, hole_count, output ready);
endinterface

// ----- src/fit_policy_byte_allocator_top.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Word fields
// in_ch    in   req_type, size, address
// out_ch   out  status, address_out, free_bytes, hole_count
// cfg_*    in   we, index, wdata (fit_mode, base_address)
// Allocate: full map scan; if a hole fits, table walk (up to MAX_BLOCKS entries),
// marking of size+HEADER_BYTES bytes, then a second map scan for the hole count.
// Free: table walk, byte clearing, one map scan. The map is a 1-bit memory
// read one byte per cycle. After reset a clearing pass over all MEM_BYTES bytes runs
// before in_ch.ready rises. A finished word waits in the output register.
module fit_policy_byte_allocator_top import fpba_pkg::*; #(
  parameter int MEM_BYTES    = P_MEM_BYTES,
  parameter int MAX_BLOCKS   = P_MAX_BLOCKS,
  parameter int HEADER_BYTES = P_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fpba_req_if.sink             in_ch,
  fpba_rsp_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  fpba_cmd_t cmd;
  fpba_sts_t sts;

  fpba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  fpba_dp #(
    .MEM_BYTES    (MEM_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_ch.req_type),
    .in_size         (in_ch.size),
    .in_address      (in_ch.address),
    .out_status      (out_ch.status),
    .out_address_out (out_ch.address_out),
    .out_free_bytes  (out_ch.free_bytes),
    .out_hole_count  (out_ch.hole_count)
  );

endmodule

// ----- src/fpba_ctrl.sv -----
`timescale 1ns / 1ps
module fpba_ctrl import fpba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fpba_sts_t sts,
  output fpba_cmd_t cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_IDLE   = 4'd2;
  localparam logic [3:0] S_SCAN1  = 4'd3;
  localparam logic [3:0] S_LOOK   = 4'd4;
  localparam logic [3:0] S_COMMIT = 4'd5;
  localparam logic [3:0] S_MARK   = 4'd6;
  localparam logic [3:0] S_SCAN2  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       req_free_r, req_free_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    req_free_nxt = req_free_r;
    cmd          = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_start = 1'b1;
        state_nxt     = S_CLR;
      end
      S_CLR: begin
        cmd.mark_run = 1'b1;
        if (sts.mark_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          req_free_nxt = (in_req_type == REQ_FREE);
          if (in_req_type == REQ_FREE) begin
            cmd.look_start = 1'b1;
            state_nxt      = S_LOOK;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN1;
          end
        end
      end
      S_SCAN1: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.look_start = 1'b1;
            state_nxt      = S_LOOK;
          end else begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NOSPACE;
            state_nxt   = S_FIN;
          end
        end
      end
      S_LOOK: begin
        cmd.look_run = 1'b1;
        if (sts.look_hit) begin
          state_nxt = S_COMMIT;
        end else if (sts.look_last) begin
          cmd.set_st     = 1'b1;
          cmd.st_code    = req_free_r ? ST_UNKNOWN : ST_FULL;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN2;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_MARK;
      end
      S_MARK: begin
        cmd.mark_run = 1'b1;
        if (sts.mark_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN2;
        end
      end
      S_SCAN2: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      req_free_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      req_free_r  <= req_free_nxt;
    end
  end

endmodule

// ----- src/fpba_dp.sv -----
`timescale 1ns / 1ps
module fpba_dp import fpba_pkg::*; #(
  parameter int MEM_BYTES    = P_MEM_BYTES,
  parameter int MAX_BLOCKS   = P_MAX_BLOCKS,
  parameter int HEADER_BYTES = P_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpba_cmd_t            cmd,
  output fpba_sts_t            sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 in_req_type,
  input  logic [SIZE_W-1:0]    in_size,
  input  logic [ADDR_W-1:0]    in_address,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_address_out,
  output logic [FREE_W-1:0]    out_free_bytes,
  output logic [HOLES_W-1:0]   out_hole_count
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = AW + 1;
  localparam int LW = (PW > NEED_W) ? PW : NEED_W;
  localparam int KW = $clog2(MAX_BLOCKS);

  logic              used_map [MEM_BYTES];
  logic              map_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] base_r;

  logic              req_free_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LW-1:0]     need_r;
  logic [AW-1:0]     at_r;
  logic [KW-1:0]     slot_r;

  logic [AW-1:0]     boff_r  [MAX_BLOCKS];
  logic [SIZE_W-1:0] bsize_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] bvalid_r;
  logic [PW-1:0]     fc_r;

  logic [PW-1:0]     sc_r;
  logic              rv_r;
  logic [AW-1:0]     rpos_r;
  logic              prev_r;
  logic [AW-1:0]     run_start_r;
  logic [PW-1:0]     run_len_r;
  logic [PW-1:0]     holes_r;
  logic              found_r;
  logic [PW-1:0]     best_len_r;

  logic [KW-1:0]     k_r;
  logic [PW-1:0]     mpos_r;
  logic [LW-1:0]     mcnt_r;
  logic [LW-1:0]     mlen_r;
  logic              mval_r;
  logic              mark_act;

  logic [STATUS_W-1:0] st_r;
  logic [ADDR_W-1:0]   aout_r;
  logic [STATUS_W-1:0] o_st_r;
  logic [ADDR_W-1:0]   o_addr_r;
  logic [FREE_W-1:0]   o_free_r;
  logic [HOLES_W-1:0]  o_holes_r;

  logic [AW-1:0] cur_start, ev_start;
  logic [PW-1:0] cur_len, ev_len;
  logic          end_ev, fits, take;
  logic          look_hit, look_match;

  assign rd_en   = cmd.scan_run && (sc_r < PW'(MEM_BYTES));
  assign rd_addr = sc_r[AW-1:0];
  assign mark_act = (mcnt_r < mlen_r) && (mpos_r < PW'(MEM_BYTES));
  assign wr_en   = cmd.mark_run && mark_act;

  always_ff @(posedge clk) begin
    if (wr_en) used_map[mpos_r[AW-1:0]] <= mval_r;
    if (rd_en) map_q <= used_map[rd_addr];
  end

  always_comb begin
    cur_start = prev_r ? rpos_r : run_start_r;
    cur_len   = prev_r ? PW'(1) : run_len_r + PW'(1);
    end_ev    = rv_r && ((map_q && !prev_r) ||
                         (!map_q && (rpos_r == AW'(MEM_BYTES - 1))));
    ev_start  = map_q ? run_start_r : cur_start;
    ev_len    = map_q ? run_len_r : cur_len;
    fits      = LW'(ev_len) >= need_r;
    case (mode_r)
      MODE_BEST:  take = !found_r || (ev_len <= best_len_r);
      MODE_WORST: take = !found_r || (ev_len >= best_len_r);
      default:    take = !found_r;
    endcase
  end

  assign look_match = (base_r + ADDR_W'(boff_r[k_r]) + ADDR_W'(HEADER_BYTES)) == addr_r;
  assign look_hit   = req_free_r ? (bvalid_r[k_r] && look_match) : !bvalid_r[k_r];

  assign sts.scan_done = (sc_r == PW'(MEM_BYTES)) && !rv_r;
  assign sts.found     = found_r;
  assign sts.look_hit  = look_hit;
  assign sts.look_last = (k_r == KW'(MAX_BLOCKS - 1));
  assign sts.mark_done = !mark_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FIRST;
      base_r   <= '0;
      bvalid_r <= '0;
      fc_r     <= PW'(MEM_BYTES);
      rv_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
          CFG_BASE:     base_r <= cfg_wdata;
          default:      ;
        endcase
      end
      rv_r <= rd_en;
      if (cmd.commit) begin
        if (req_free_r) begin
          bvalid_r[slot_r] <= 1'b0;
          fc_r <= fc_r + PW'(need_r);
        end else begin
          bvalid_r[slot_r] <= 1'b1;
          fc_r <= fc_r - PW'(need_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free_r <= (in_req_type == REQ_FREE);
      size_r     <= in_size;
      addr_r     <= in_address;
      need_r     <= LW'(in_size) + LW'(HEADER_BYTES);
      st_r       <= ST_OK;
      aout_r     <= '0;
    end
    if (cmd.set_st) st_r <= cmd.st_code;

    if (cmd.scan_start) begin
      sc_r        <= '0;
      prev_r      <= 1'b1;
      run_start_r <= '0;
      run_len_r   <= '0;
      holes_r     <= '0;
      found_r     <= 1'b0;
      best_len_r  <= '0;
    end else if (cmd.scan_run) begin
      if (rd_en) begin
        sc_r   <= sc_r + PW'(1);
        rpos_r <= sc_r[AW-1:0];
      end
      if (rv_r) begin
        if (!map_q) begin
          if (prev_r) holes_r <= holes_r + PW'(1);
          run_start_r <= cur_start;
          run_len_r   <= cur_len;
        end
        prev_r <= map_q;
        if (end_ev && fits && take) begin
          found_r    <= 1'b1;
          best_len_r <= ev_len;
          at_r       <= ev_start;
        end
      end
    end

    if (cmd.look_start) begin
      k_r <= '0;
    end else if (cmd.look_run) begin
      if (look_hit) begin
        slot_r <= k_r;
        if (req_free_r) begin
          at_r   <= boff_r[k_r];
          need_r <= LW'(bsize_r[k_r]) + LW'(HEADER_BYTES);
        end
      end else begin
        k_r <= k_r + KW'(1);
      end
    end

    if (cmd.clr_start) begin
      mpos_r <= '0;
      mcnt_r <= '0;
      mlen_r <= LW'(MEM_BYTES);
      mval_r <= 1'b0;
    end else if (cmd.commit) begin
      mpos_r <= PW'(at_r);
      mcnt_r <= '0;
      mlen_r <= need_r;
      mval_r <= !req_free_r;
      if (!req_free_r) begin
        boff_r[slot_r]  <= at_r;
        bsize_r[slot_r] <= size_r;
        aout_r <= base_r + ADDR_W'(at_r) + ADDR_W'(HEADER_BYTES);
      end
    end else if (wr_en) begin
      mpos_r <= mpos_r + PW'(1);
      mcnt_r <= mcnt_r + LW'(1);
    end

    if (cmd.out_load) begin
      o_st_r    <= st_r;
      o_addr_r  <= aout_r;
      o_free_r  <= FREE_W'(fc_r);
      o_holes_r <= HOLES_W'(holes_r);
    end
  end

  assign out_status      = o_st_r;
  assign out_address_out = o_addr_r;
  assign out_free_bytes  = o_free_r;
  assign out_hole_count  = o_holes_r;

endmodule
